// ----- src/swhs_pkg.sv -----
// types and constants shared by the single-wire humidity sensor reader
// no dependencies; used by swhs_cfg, swhs_fsm and the top level
package swhs_pkg;

	localparam int unsigned FRAME_BITS = 40;
	localparam int unsigned BIT_IDX_W  = 6;
	localparam int unsigned ADDR_W     = 4;
	localparam int unsigned DATA_W     = 32;

	localparam logic [15:0] START_LOW_RESET = 16'd10000;
	localparam logic [7:0]  RELEASE_RESET   = 8'd40;
	localparam logic [7:0]  THRESHOLD_RESET = 8'd50;

	// register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_START_LOW = 2'd0,
		REG_RELEASE   = 2'd1,
		REG_THRESHOLD = 2'd2,
		REG_NONE      = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_START_LOW = 3'd1,
		PH_START_HI  = 3'd2,
		PH_ACK_LOW1  = 3'd3,
		PH_ACK_HIGH  = 3'd4,
		PH_ACK_LOW2  = 3'd5,
		PH_BIT_WAIT  = 3'd6,
		PH_BIT_HIGH  = 3'd7
	} phase_t;

	typedef enum logic {
		KIND_TICK  = 1'b0,
		KIND_START = 1'b1
	} kind_t;

	typedef enum logic {
		STAT_OK       = 1'b0,
		STAT_CHECKSUM = 1'b1
	} status_t;

	typedef struct packed {
		logic [15:0] start_low_ticks;
		logic [7:0]  release_ticks;
		logic [7:0]  one_threshold;
	} cfg_t;

	typedef struct packed {
		logic               drive_enable;
		logic               drive_level;
		logic               busy;
		logic               done;
		logic               status;
		logic [15:0]        humidity_tenths;
		logic signed [15:0] temp_tenths;
	} res_t;

endpackage

// ----- src/swhs_cfg.sv -----
// apb register file: start low time, release time and one threshold
// depends on swhs_pkg
module swhs_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [swhs_pkg::ADDR_W-1:0]         paddr,
	input  logic [swhs_pkg::DATA_W-1:0]         pwdata,
	output logic [swhs_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	output swhs_pkg::cfg_t                      cfg
);

	swhs_pkg::cfg_t     cfg_q;
	swhs_pkg::reg_idx_t idx;
	logic               wr_en;

	assign idx    = swhs_pkg::reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_low_ticks <= swhs_pkg::START_LOW_RESET;
			cfg_q.release_ticks   <= swhs_pkg::RELEASE_RESET;
			cfg_q.one_threshold   <= swhs_pkg::THRESHOLD_RESET;
		end else if (wr_en) begin
			unique case (idx)
				swhs_pkg::REG_START_LOW: cfg_q.start_low_ticks <= pwdata[15:0];
				swhs_pkg::REG_RELEASE:   cfg_q.release_ticks   <= pwdata[7:0];
				swhs_pkg::REG_THRESHOLD: cfg_q.one_threshold   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			swhs_pkg::REG_START_LOW: prdata = {16'd0, cfg_q.start_low_ticks};
			swhs_pkg::REG_RELEASE:   prdata = {24'd0, cfg_q.release_ticks};
			swhs_pkg::REG_THRESHOLD: prdata = {24'd0, cfg_q.one_threshold};
			default:                 prdata = '0;
		endcase
	end

endmodule

// ----- src/swhs_fsm.sv -----
// protocol state machine: start pulse, acknowledge, 40 bit pulse decode,
// checksum and conversion; depends on swhs_pkg
module swhs_fsm (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic            kind,
	input  logic            line_level,
	input  swhs_pkg::cfg_t  cfg,
	output swhs_pkg::res_t  res
);

	swhs_pkg::phase_t                   phase_q, phase_d;
	logic [15:0]                        tick_q, tick_d, tick_inc, lim;
	logic [7:0]                         pulse_q, pulse_d;
	logic [swhs_pkg::BIT_IDX_W-1:0]     bit_q, bit_d, bit_inc;
	logic [swhs_pkg::FRAME_BITS-1:0]    frame_q, frame_d, frame_n;
	logic                               idle_drv_q, idle_drv_d;
	logic [7:0]                         b0, b1, b2, b3, b4;
	logic [9:0]                         sum;
	logic [14:0]                        mag;
	logic [15:0]                        temp_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= swhs_pkg::PH_IDLE;
			tick_q     <= '0;
			pulse_q    <= '0;
			bit_q      <= '0;
			frame_q    <= '0;
			idle_drv_q <= 1'b0;
		end else if (fire) begin
			phase_q    <= phase_d;
			tick_q     <= tick_d;
			pulse_q    <= pulse_d;
			bit_q      <= bit_d;
			frame_q    <= frame_d;
			idle_drv_q <= idle_drv_d;
		end
	end

	// frame with the bit that ends the current pulse shifted in
	assign frame_n  = {frame_q[swhs_pkg::FRAME_BITS-2:0], (pulse_q > cfg.one_threshold)};
	assign b0       = frame_n[39:32];
	assign b1       = frame_n[31:24];
	assign b2       = frame_n[23:16];
	assign b3       = frame_n[15:8];
	assign b4       = frame_n[7:0];
	assign sum      = {2'b00, b0} + {2'b00, b1} + {2'b00, b2} + {2'b00, b3};
	assign mag      = {b2[6:0], b3};
	// sign-magnitude to two's complement; negative zero stays zero
	assign temp_raw = b2[7] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
	assign tick_inc = (tick_q != 16'hFFFF) ? (tick_q + 16'd1) : tick_q;
	assign lim      = (phase_q == swhs_pkg::PH_START_LOW) ? cfg.start_low_ticks
	                                                      : {8'd0, cfg.release_ticks};
	assign bit_inc  = bit_q + 1'b1;

	always_comb begin
		phase_d    = phase_q;
		tick_d     = tick_q;
		pulse_d    = pulse_q;
		bit_d      = bit_q;
		frame_d    = frame_q;
		idle_drv_d = idle_drv_q;
		res        = '0;
		if (kind == swhs_pkg::KIND_START) begin
			if (phase_q == swhs_pkg::PH_IDLE) begin
				phase_d = swhs_pkg::PH_START_LOW;
				tick_d  = '0;
				pulse_d = '0;
				bit_d   = '0;
				frame_d = '0;
			end
		end else begin
			unique case (phase_q)
				swhs_pkg::PH_START_LOW, swhs_pkg::PH_START_HI: begin
					tick_d = tick_inc;
					if (tick_inc >= lim) begin
						tick_d  = '0;
						phase_d = (phase_q == swhs_pkg::PH_START_LOW) ?
						          swhs_pkg::PH_START_HI : swhs_pkg::PH_ACK_LOW1;
					end
				end
				swhs_pkg::PH_ACK_LOW1: begin
					if (!line_level) phase_d = swhs_pkg::PH_ACK_HIGH;
				end
				swhs_pkg::PH_ACK_HIGH: begin
					if (line_level) phase_d = swhs_pkg::PH_ACK_LOW2;
				end
				swhs_pkg::PH_ACK_LOW2: begin
					if (!line_level) phase_d = swhs_pkg::PH_BIT_WAIT;
				end
				swhs_pkg::PH_BIT_WAIT: begin
					if (line_level) begin
						pulse_d = 8'd1;
						phase_d = swhs_pkg::PH_BIT_HIGH;
					end
				end
				swhs_pkg::PH_BIT_HIGH: begin
					if (line_level) begin
						if (pulse_q != 8'hFF) pulse_d = pulse_q + 8'd1;
					end else begin
						frame_d = frame_n;
						pulse_d = '0;
						if (bit_inc >= swhs_pkg::BIT_IDX_W'(swhs_pkg::FRAME_BITS)) begin
							res.done   = 1'b1;
							phase_d    = swhs_pkg::PH_IDLE;
							bit_d      = '0;
							idle_drv_d = 1'b1;
							if (b4 == sum[7:0]) begin
								res.status          = swhs_pkg::STAT_OK;
								res.humidity_tenths = {b0, b1};
								res.temp_tenths     = temp_raw;
							end else begin
								res.status = swhs_pkg::STAT_CHECKSUM;
							end
						end else begin
							bit_d   = bit_inc;
							phase_d = swhs_pkg::PH_BIT_WAIT;
						end
					end
				end
				default: ;
			endcase
		end
		// line drive follows the phase after this item
		if (phase_d == swhs_pkg::PH_IDLE) begin
			res.drive_enable = idle_drv_d;
			res.drive_level  = idle_drv_d;
			res.busy         = 1'b0;
		end else begin
			res.drive_enable = (phase_d == swhs_pkg::PH_START_LOW) ||
			                   (phase_d == swhs_pkg::PH_START_HI);
			res.drive_level  = (phase_d == swhs_pkg::PH_START_HI);
			res.busy         = 1'b1;
		end
	end

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.done) |=> (phase_q == swhs_pkg::PH_IDLE && bit_q == '0))
		else $error("reading completed without returning to idle");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q < swhs_pkg::BIT_IDX_W'(swhs_pkg::FRAME_BITS))
		else $error("bit index past frame length");

	a_bad_sum_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.status) |-> (res.done && res.humidity_tenths == '0 &&
		                          res.temp_tenths == '0))
		else $error("checksum error with data or without done");

	a_drive_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == swhs_pkg::PH_IDLE && !idle_drv_q && fire && !kind) |-> !res.drive_enable)
		else $error("line driven before any reading completed");

endmodule

// ----- src/single_wire_humidity_sensor_reader.sv -----
// top level of the single-wire humidity sensor reader: input and result
// registers around swhs_fsm, apb registers in swhs_cfg; depends on swhs_pkg
//
// usage:
//   input channel (in_valid/in_stall, kind, line_level): kind 0 is one 1 us
//   tick carrying the sampled data line, kind 1 requests a reading (ignored
//   while busy). every input item gives exactly one result item.
//   result channel (out_valid/out_stall): line drive controls, busy, a done
//   pulse and, on done, status, humidity and temperature in tenths.
//   configuration goes through the apb port; registers at 0x0, 0x4, 0x8.
// path: an accepted item passes the input register, then the result register,
//   before it shows on the result ports.
// throughput: one item per cycle while the result channel is not stalled; the state
//   update is a registered loop through the protocol state machine.
// reset: line released, idle, registers back to defaults.
// when the receiver stalls the result register holds; an empty input
//   register still takes one more item, then in_stall stays high until the
//   result drains.
module single_wire_humidity_sensor_reader (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         kind,
	input  logic                         line_level,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         drive_enable,
	output logic                         drive_level,
	output logic                         busy_res,
	output logic                         done_res,
	output logic                         status,
	output logic [15:0]                  humidity_tenths,
	output logic signed [15:0]           temp_tenths,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [swhs_pkg::ADDR_W-1:0]  paddr,
	input  logic [swhs_pkg::DATA_W-1:0]  pwdata,
	output logic [swhs_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);

	swhs_pkg::cfg_t cfg;
	swhs_pkg::res_t res;
	swhs_pkg::res_t res_s2;
	logic           valid_s1, kind_s1, line_s1;
	logic           valid_s2;
	logic           advance;

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			res_s2   <= '0;
		end else begin
			if (!in_stall) valid_s1 <= in_valid;
			if (advance)   valid_s2 <= valid_s1;
			if (valid_s1 && advance) res_s2 <= res;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			line_s1 <= line_level;
		end
	end

	swhs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	swhs_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (valid_s1 && advance),
		.kind       (kind_s1),
		.line_level (line_s1),
		.cfg        (cfg),
		.res        (res)
	);

	assign out_valid       = valid_s2;
	assign drive_enable    = res_s2.drive_enable;
	assign drive_level     = res_s2.drive_level;
	assign busy_res        = res_s2.busy;
	assign done_res        = res_s2.done;
	assign status          = res_s2.status;
	assign humidity_tenths = res_s2.humidity_tenths;
	assign temp_tenths     = res_s2.temp_tenths;

endmodule

// ----- tb/single_wire_humidity_sensor_reader_test.sv -----
`timescale 1ns / 100ps
// self-checking bench for single_wire_humidity_sensor_reader: drives ticks and start requests,
// plays the sensor's acknowledge and bit pulses, predicts every result and checks it
// depends on swhs_pkg and the reader's top level only
module single_wire_humidity_sensor_reader_test;

	typedef struct packed {
		swhs_pkg::kind_t kind;
		logic            line;
	} sample_t;

	typedef struct {
		swhs_pkg::phase_t ph;
		logic [15:0]      ticks;
		logic [7:0]       plen;
		logic [5:0]       nbits;
		logic [39:0]      frame;
		logic             idle_hi;
		logic             idle_drv;
	} reader_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic kind = 1'b0;
	logic line_level = 1'b0;
	logic out_stall = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [swhs_pkg::ADDR_W-1:0] paddr = '0;
	logic [swhs_pkg::DATA_W-1:0] pwdata = '0;
	logic in_stall, out_valid, drive_enable, drive_level, busy_res, done_res, status, pready;
	logic [15:0] humidity_tenths;
	logic signed [15:0] temp_tenths;
	logic [swhs_pkg::DATA_W-1:0] prdata;

	sample_t        pending[$];
	swhs_pkg::res_t reading_q[$];
	swhs_pkg::cfg_t cfg;
	reader_t        live;   // follows the items the block has accepted
	reader_t        plan;   // follows the items queued for sending
	swhs_pkg::res_t next_res;
	swhs_pkg::res_t want;
	sample_t        nxt;
	int             idle_pct = 0;
	int             stall_pct = 0;
	int             queued = 0;
	int             mismatches = 0;

	single_wire_humidity_sensor_reader uut (.*);

	always #5 clk = ~clk;

	function automatic reader_t reader_reset();
		reader_t s;
		s.ph = swhs_pkg::PH_IDLE;
		s.ticks = '0;
		s.plen = '0;
		s.nbits = '0;
		s.frame = '0;
		s.idle_hi = 1'b1;
		s.idle_drv = 1'b0;
		return s;
	endfunction

	function automatic swhs_pkg::res_t reader_step(inout reader_t s, input swhs_pkg::cfg_t c,
			input swhs_pkg::kind_t k, input logic ln);
		swhs_pkg::res_t r;
		logic [15:0] lim;
		logic [7:0] b0, b1, b2, b3, b4, sum;
		logic [15:0] mag;
		r = '0;
		if (k == swhs_pkg::KIND_START) begin
			if (s.ph == swhs_pkg::PH_IDLE) begin
				s.ph = swhs_pkg::PH_START_LOW;
				s.ticks = '0;
				s.plen = '0;
				s.nbits = '0;
				s.frame = '0;
			end
		end else begin
			unique case (s.ph)
			swhs_pkg::PH_START_LOW, swhs_pkg::PH_START_HI: begin
				lim = (s.ph == swhs_pkg::PH_START_LOW) ? c.start_low_ticks
					: {8'd0, c.release_ticks};
				if (s.ticks != 16'hFFFF)
					s.ticks++;
				if (s.ticks >= lim) begin
					s.ticks = '0;
					s.ph = (s.ph == swhs_pkg::PH_START_LOW) ? swhs_pkg::PH_START_HI
						: swhs_pkg::PH_ACK_LOW1;
				end
			end
			swhs_pkg::PH_ACK_LOW1: if (!ln) s.ph = swhs_pkg::PH_ACK_HIGH;
			swhs_pkg::PH_ACK_HIGH: if (ln) s.ph = swhs_pkg::PH_ACK_LOW2;
			swhs_pkg::PH_ACK_LOW2: if (!ln) s.ph = swhs_pkg::PH_BIT_WAIT;
			swhs_pkg::PH_BIT_WAIT: if (ln) begin
				s.plen = 8'd1;
				s.ph = swhs_pkg::PH_BIT_HIGH;
			end
			swhs_pkg::PH_BIT_HIGH: if (ln) begin
				if (s.plen != 8'hFF)
					s.plen++;
			end else begin
				s.frame = {s.frame[38:0], s.plen > c.one_threshold};
				s.nbits++;
				s.plen = '0;
				if (s.nbits >= swhs_pkg::FRAME_BITS) begin
					{b0, b1, b2, b3, b4} = s.frame;
					sum = b0 + b1 + b2 + b3;
					r.done = 1'b1;
					if (b4 == sum) begin
						r.humidity_tenths = {b0, b1};
						// sign-magnitude temperature, negative zero comes out as zero
						mag = {1'b0, b2[6:0], b3};
						r.temp_tenths = b2[7] ? -mag : mag;
					end else begin
						r.status = swhs_pkg::STAT_CHECKSUM;
					end
					s.ph = swhs_pkg::PH_IDLE;
					s.nbits = '0;
					s.idle_drv = 1'b1;
					s.idle_hi = 1'b1;
				end else begin
					s.ph = swhs_pkg::PH_BIT_WAIT;
				end
			end
			default: ;
			endcase
		end
		if (s.ph == swhs_pkg::PH_IDLE) begin
			r.drive_enable = s.idle_drv;
			r.drive_level = s.idle_drv & s.idle_hi;
			r.busy = 1'b0;
		end else begin
			r.drive_enable = (s.ph == swhs_pkg::PH_START_LOW) || (s.ph == swhs_pkg::PH_START_HI);
			r.drive_level = (s.ph == swhs_pkg::PH_START_HI);
			r.busy = 1'b1;
		end
		return r;
	endfunction

	// item source
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				next_res = reader_step(live, cfg, swhs_pkg::kind_t'(kind), line_level);
				reading_q.push_back(next_res);
			end
			if (!in_valid || !in_stall) begin
				if (pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
					nxt = pending.pop_front();
					in_valid <= 1'b1;
					kind <= nxt.kind;
					line_level <= nxt.line;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic compare(string name, logic [15:0] exp_val, logic [15:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, act_val);
			mismatches++;
		end
	endtask

	// result sink
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (reading_q.size() == 0) begin
					$error("result item arrived with none outstanding");
					mismatches++;
				end else begin
					want = reading_q.pop_front();
					compare("drive_enable", 16'(want.drive_enable), 16'(drive_enable));
					compare("drive_level", 16'(want.drive_level), 16'(drive_level));
					compare("busy_res", 16'(want.busy), 16'(busy_res));
					compare("done_res", 16'(want.done), 16'(done_res));
					compare("status", 16'(want.status), 16'(status));
					compare("humidity_tenths", want.humidity_tenths, humidity_tenths);
					compare("temp_tenths", want.temp_tenths, temp_tenths);
				end
			end
			out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
		end
	end

	task automatic set_reg(swhs_pkg::reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		unique case (idx)
		swhs_pkg::REG_START_LOW: cfg.start_low_ticks = val[15:0];
		swhs_pkg::REG_RELEASE:   cfg.release_ticks = val[7:0];
		swhs_pkg::REG_THRESHOLD: cfg.one_threshold = val[7:0];
		default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending.size() != 0 || in_valid || reading_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_pace(int send_idle, int recv_stall);
		@(negedge clk);
		idle_pct = send_idle;
		stall_pct = recv_stall;
	endtask

	task automatic feed(swhs_pkg::kind_t k, logic ln);
		void'(reader_step(plan, cfg, k, ln));
		pending.push_back('{k, ln});
		queued++;
	endtask

	// drive the line the way the current phase waits for, until the reader is idle again
	task automatic settle();
		while (plan.ph != swhs_pkg::PH_IDLE) begin
			unique case (plan.ph)
			swhs_pkg::PH_ACK_LOW1, swhs_pkg::PH_ACK_LOW2, swhs_pkg::PH_BIT_HIGH:
				feed(swhs_pkg::KIND_TICK, 1'b0);
			swhs_pkg::PH_ACK_HIGH, swhs_pkg::PH_BIT_WAIT:
				feed(swhs_pkg::KIND_TICK, 1'b1);
			default: feed(swhs_pkg::KIND_TICK, 1'($urandom));
			endcase
		end
	endtask

	function automatic int pulse_for(logic b);
		int thr = cfg.one_threshold;
		if (b)
			return thr + 1 + (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
		if (thr == 0)
			return 1;
		return ($urandom_range(3) == 0) ? thr : $urandom_range(1, (thr < 4) ? thr : 4);
	endfunction

	function automatic logic [39:0] frame_of(logic [15:0] hum, logic [15:0] tmp, logic good);
		logic [7:0] sum;
		sum = hum[15:8] + hum[7:0] + tmp[15:8] + tmp[7:0];
		if (!good)
			sum = sum + 8'($urandom_range(1, 255));
		return {hum, tmp, sum};
	endfunction

	// one sensor transaction; long_bit gets a pulse past the counter's saturation
	task automatic reading(logic [39:0] frame, int long_bit, int junk_pct);
		int n;
		settle();
		feed(swhs_pkg::KIND_START, 1'($urandom));
		while (plan.ph inside {swhs_pkg::PH_START_LOW, swhs_pkg::PH_START_HI}) begin
			if ($urandom_range(99) < junk_pct)
				feed(swhs_pkg::KIND_START, 1'($urandom));
			else
				feed(swhs_pkg::KIND_TICK, 1'($urandom));
		end
		repeat ($urandom_range(0, 2)) feed(swhs_pkg::KIND_TICK, 1'b1);
		repeat ($urandom_range(1, 3)) feed(swhs_pkg::KIND_TICK, 1'b0);
		repeat ($urandom_range(1, 3)) feed(swhs_pkg::KIND_TICK, 1'b1);
		repeat ($urandom_range(1, 3)) feed(swhs_pkg::KIND_TICK, 1'b0);
		for (int i = 39; i >= 0; i--) begin
			if ($urandom_range(99) < junk_pct)
				feed(swhs_pkg::KIND_START, 1'($urandom));
			n = (i == long_bit) ? 258 : pulse_for(frame[i]);
			repeat (n) feed(swhs_pkg::KIND_TICK, 1'b1);
			repeat ($urandom_range(1, 2)) feed(swhs_pkg::KIND_TICK, 1'b0);
		end
	endtask

	task automatic random_mode(int send_idle, int recv_stall, int budget);
		int target;
		int pick;
		wait_drained();
		set_reg(swhs_pkg::REG_START_LOW, ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6));
		set_reg(swhs_pkg::REG_RELEASE, $urandom_range(1, 3));
		set_reg(swhs_pkg::REG_THRESHOLD, $urandom_range(1, 2));
		set_pace(send_idle, recv_stall);
		target = queued + budget;
		while (queued < target) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				reading(frame_of(($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom),
					16'($urandom), $urandom_range(99) < 80), -1, 5);
			end else if (pick < 88) begin
				repeat ($urandom_range(3, 15))
					feed(($urandom_range(4) == 0) ? swhs_pkg::KIND_START : swhs_pkg::KIND_TICK,
						1'($urandom));
			end else begin
				// sequence cut short: start, then line noise
				feed(swhs_pkg::KIND_START, 1'($urandom));
				repeat ($urandom_range(5, 40)) feed(swhs_pkg::KIND_TICK, 1'($urandom));
			end
		end
		settle();
	endtask

	initial begin
		cfg = '{swhs_pkg::START_LOW_RESET, swhs_pkg::RELEASE_RESET, swhs_pkg::THRESHOLD_RESET};
		live = reader_reset();
		plan = reader_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// short timing so one reading stays small
		set_reg(swhs_pkg::REG_START_LOW, 32'd3);
		set_reg(swhs_pkg::REG_RELEASE, 32'd2);
		set_reg(swhs_pkg::REG_THRESHOLD, 32'd1);
		set_pace(0, 0);
		// full-scale humidity, sign set with zero magnitude, one pulse past saturation
		reading(frame_of(16'hFFFF, 16'h8000, 1'b1), 30, 0);
		wait_drained();

		// zero counts behave as one tick, zero threshold makes every bit a one
		set_reg(swhs_pkg::REG_START_LOW, 32'd0);
		set_reg(swhs_pkg::REG_RELEASE, 32'd0);
		set_reg(swhs_pkg::REG_THRESHOLD, 32'd0);
		set_pace(0, 0);
		reading(frame_of(16'h00AA, 16'h0055, 1'b1), -1, 0);

		random_mode(0, 0, 100);
		random_mode(75, 0, 100);
		random_mode(0, 75, 100);
		random_mode(30, 30, 100);

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && reading_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#(1_000_000);
		$display("Mismatches found");
		$finish;
	end

endmodule
